// ===== hw/rtl/fpwb_pkg.sv =====
// Package for the flash page write-back cache: sizes, request codes and the
// request/result structs shared by the flash array, page buffer and sequencer.
// No dependencies.
package fpwb_pkg;

  localparam int unsigned PAGE_WORDS  = 1024;
  localparam int unsigned FLASH_PAGES = 16;

  localparam int unsigned ADDR_W      = 14;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned REQ_W       = 2;
  localparam int unsigned PROG_PAGE_W = 4;

  localparam int unsigned PAGE_AW     = $clog2(PAGE_WORDS);
  localparam int unsigned APG_W       = ADDR_W - PAGE_AW;
  localparam int unsigned PAGE_IDX_W  = (FLASH_PAGES > 1) ? $clog2(FLASH_PAGES) : 1;
  localparam int unsigned FL_AW       = PAGE_IDX_W + PAGE_AW;
  localparam int unsigned FLASH_WORDS = FLASH_PAGES * PAGE_WORDS;
  localparam int unsigned CNT_W       = PAGE_AW + 1;

  localparam logic [DATA_W-1:0] ERASED_WORD = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_FLUSH = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_PROG,
    S_LOAD,
    S_STORE
  } state_e;

  typedef struct packed {
    logic              re;
    logic [FL_AW-1:0]  raddr;
    logic              we;
    logic [FL_AW-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
  } fl_req_t;

  typedef struct packed {
    logic               re;
    logic [PAGE_AW-1:0] raddr;
    logic               we;
    logic [PAGE_AW-1:0] waddr;
    logic [DATA_W-1:0]  wdata;
  } buf_req_t;

  typedef struct packed {
    logic                   valid;
    logic [DATA_W-1:0]      read_data;
    logic                   programmed;
    logic [PROG_PAGE_W-1:0] page;
  } res_t;

endpackage

// ===== hw/rtl/fpwb_flash.sv =====
// Modeled flash array: one write port, one registered read port.
// Per-page valid bits stand in for the erased state after reset.
// Depends on fpwb_pkg.
module fpwb_flash import fpwb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fl_req_t           req_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0]      mem [FLASH_WORDS];
  logic [FLASH_PAGES-1:0] pv_q;
  logic [DATA_W-1:0]      rd_q;
  logic                   rd_pv_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q    <= '0;
      rd_pv_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        pv_q[req_i.waddr[FL_AW-1:PAGE_AW]] <= 1'b1;
      end
      if (req_i.re) begin
        rd_pv_q <= pv_q[req_i.raddr[FL_AW-1:PAGE_AW]];
      end
    end
  end

  assign rdata_o = rd_pv_q ? rd_q : ERASED_WORD;

endmodule

// ===== hw/rtl/fpwb_buf.sv =====
// Page buffer holding the cached page: one write port, one registered read port.
// Depends on fpwb_pkg.
module fpwb_buf import fpwb_pkg::*; (
  input  logic              clk_i,
  input  buf_req_t          req_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [PAGE_WORDS];
  logic [DATA_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rd_q;

endmodule

// ===== hw/rtl/fpwb_seq.sv =====
// Sequencer: cache tag state, one word counter reused for the compare, program and
// reload sweeps, and one word comparator for the compare sweep. Depends on fpwb_pkg.
module fpwb_seq import fpwb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [ADDR_W-1:0] word_addr_i,
  input  logic [DATA_W-1:0] write_data_i,
  output logic              busy_o,
  output fl_req_t           fl_o,
  input  logic [DATA_W-1:0] fl_rdata_i,
  output buf_req_t          bf_o,
  input  logic [DATA_W-1:0] bf_rdata_i,
  output res_t              res_o
);

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  diff_q, diff_d;
  logic                  wr_q, wr_d;
  logic                  prog_q, prog_d;
  logic                  cv_q, cv_d;
  logic [PAGE_IDX_W-1:0] cp_q, cp_d;
  logic [PAGE_IDX_W-1:0] np_q, np_d;
  logic [PAGE_AW-1:0]    off_q, off_d;
  logic [DATA_W-1:0]     data_q, data_d;

  logic [APG_W-1:0]      addr_page;
  logic [PAGE_IDX_W-1:0] req_page;
  logic [PAGE_AW-1:0]    req_off;
  logic                  in_range;
  logic [PAGE_AW-1:0]    idx;
  logic [PAGE_AW-1:0]    widx;
  logic                  cnt_end;
  logic                  cnt_live;
  logic                  word_ne;
  logic                  diff_now;

  assign addr_page = word_addr_i[ADDR_W-1:PAGE_AW];
  assign req_page  = PAGE_IDX_W'(addr_page);
  assign req_off   = word_addr_i[PAGE_AW-1:0];
  assign in_range  = int'(addr_page) < FLASH_PAGES;
  assign idx       = cnt_q[PAGE_AW-1:0];
  assign widx      = PAGE_AW'(cnt_q - CNT_W'(1));
  assign cnt_end   = cnt_q == CNT_W'(PAGE_WORDS);
  assign cnt_live  = cnt_q != '0;
  assign word_ne   = fl_rdata_i != bf_rdata_i;
  assign diff_now  = diff_q | (cnt_live & word_ne);
  assign busy_o    = state_q != S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      diff_q  <= 1'b0;
      wr_q    <= 1'b0;
      prog_q  <= 1'b0;
      cv_q    <= 1'b0;
      cp_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      diff_q  <= diff_d;
      wr_q    <= wr_d;
      prog_q  <= prog_d;
      cv_q    <= cv_d;
      cp_q    <= cp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    np_q   <= np_d;
    off_q  <= off_d;
    data_q <= data_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    diff_d  = diff_q;
    wr_d    = wr_q;
    prog_d  = prog_q;
    cv_d    = cv_q;
    cp_d    = cp_q;
    np_d    = np_q;
    off_d   = off_q;
    data_d  = data_q;
    fl_o    = '0;
    bf_o    = '0;
    res_o   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          prog_d = 1'b0;
          diff_d = 1'b0;
          cnt_d  = '0;
          priority case (req_e'(req_type_i))
            REQ_READ: begin
              if (in_range) begin
                fl_o.re    = 1'b1;
                fl_o.raddr = {req_page, req_off};
                state_d    = S_READ;
              end else begin
                res_o.valid = 1'b1;
              end
            end
            REQ_WRITE: begin
              if (!in_range) begin
                res_o.valid = 1'b1;
              end else if (cv_q && cp_q == req_page) begin
                bf_o.we     = 1'b1;
                bf_o.waddr  = req_off;
                bf_o.wdata  = write_data_i;
                res_o.valid = 1'b1;
              end else begin
                wr_d    = 1'b1;
                np_d    = req_page;
                off_d   = req_off;
                data_d  = write_data_i;
                state_d = cv_q ? S_CMP : S_LOAD;
              end
            end
            REQ_FLUSH: begin
              wr_d = 1'b0;
              if (cv_q) begin
                state_d = S_CMP;
              end else begin
                res_o.valid = 1'b1;
              end
            end
            default: begin
              res_o.valid = 1'b1;
            end
          endcase
        end
      end

      S_READ: begin
        res_o.valid     = 1'b1;
        res_o.read_data = fl_rdata_i;
        state_d         = S_IDLE;
      end

      S_CMP: begin
        if (!cnt_end) begin
          fl_o.re    = 1'b1;
          fl_o.raddr = {cp_q, idx};
          bf_o.re    = 1'b1;
          bf_o.raddr = idx;
          cnt_d      = cnt_q + CNT_W'(1);
          diff_d     = diff_now;
        end else if (diff_now) begin
          prog_d  = 1'b1;
          cnt_d   = '0;
          state_d = S_PROG;
        end else begin
          cv_d  = 1'b0;
          cnt_d = '0;
          if (wr_q) begin
            state_d = S_LOAD;
          end else begin
            res_o.valid = 1'b1;
            state_d     = S_IDLE;
          end
        end
      end

      S_PROG: begin
        if (cnt_live) begin
          fl_o.we    = 1'b1;
          fl_o.waddr = {cp_q, widx};
          fl_o.wdata = bf_rdata_i;
        end
        if (!cnt_end) begin
          bf_o.re    = 1'b1;
          bf_o.raddr = idx;
          cnt_d      = cnt_q + CNT_W'(1);
        end else begin
          cv_d  = 1'b0;
          cnt_d = '0;
          if (wr_q) begin
            state_d = S_LOAD;
          end else begin
            res_o.valid      = 1'b1;
            res_o.programmed = 1'b1;
            res_o.page       = PROG_PAGE_W'(cp_q);
            state_d          = S_IDLE;
          end
        end
      end

      S_LOAD: begin
        if (cnt_live) begin
          bf_o.we    = 1'b1;
          bf_o.waddr = widx;
          bf_o.wdata = fl_rdata_i;
        end
        if (!cnt_end) begin
          fl_o.re    = 1'b1;
          fl_o.raddr = {np_q, idx};
          cnt_d      = cnt_q + CNT_W'(1);
        end else begin
          prog_d  = prog_q;
          cnt_d   = '0;
          state_d = S_STORE;
        end
      end

      S_STORE: begin
        bf_o.we          = 1'b1;
        bf_o.waddr       = off_q;
        bf_o.wdata       = data_q;
        res_o.valid      = 1'b1;
        res_o.programmed = prog_q;
        res_o.page       = prog_q ? PROG_PAGE_W'(cp_q) : '0;
        cp_d             = np_q;
        cv_d             = 1'b1;
        state_d          = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/flash_page_write_back_cache.sv =====
// Top level of the flash page write-back cache: handshake, result register,
// and the flash array, page buffer and sequencer. Depends on fpwb_pkg.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------------
//   in       | in_valid_i / in_stall_o | req_type_i, word_addr_i, write_data_i
//   out      | out_valid_o / out_stall_i | read_data_o, page_programmed_o,
//            |                        |   programmed_page_o
//
// Read: answered from a registered flash read. Write to the cached page, flush with
// nothing cached, bad address or unused code: answered from the idle state. Flush or
// write miss with a page cached: a compare sweep, then a program sweep if the page is
// programmed; a write miss adds a reload sweep; all sweeps run on the word counter.
// Reset clears the cache tag and the per-page flash valid bits, no clearing pass.
// A new transaction is taken only when the sequencer is idle and the result
// register is empty, so each result must drain before another transaction is taken.
module flash_page_write_back_cache import fpwb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [REQ_W-1:0]       req_type_i,
  input  logic [ADDR_W-1:0]      word_addr_i,
  input  logic [DATA_W-1:0]      write_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [DATA_W-1:0]      read_data_o,
  output logic                   page_programmed_o,
  output logic [PROG_PAGE_W-1:0] programmed_page_o
);

  logic              seq_busy;
  logic              in_acc;
  fl_req_t           fl_req;
  buf_req_t          bf_req;
  logic [DATA_W-1:0] fl_rdata;
  logic [DATA_W-1:0] bf_rdata;
  res_t              res;

  logic                   out_valid_q, out_valid_d;
  logic [DATA_W-1:0]      read_data_q, read_data_d;
  logic                   prog_q, prog_d;
  logic [PROG_PAGE_W-1:0] page_q, page_d;

  assign in_stall_o = seq_busy | out_valid_q;
  assign in_acc     = in_valid_i & ~in_stall_o;

  fpwb_flash u_flash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (fl_req),
    .rdata_o (fl_rdata)
  );

  fpwb_buf u_buf (
    .clk_i   (clk_i),
    .req_i   (bf_req),
    .rdata_o (bf_rdata)
  );

  fpwb_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (in_acc),
    .req_type_i   (req_type_i),
    .word_addr_i  (word_addr_i),
    .write_data_i (write_data_i),
    .busy_o       (seq_busy),
    .fl_o         (fl_req),
    .fl_rdata_i   (fl_rdata),
    .bf_o         (bf_req),
    .bf_rdata_i   (bf_rdata),
    .res_o        (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    read_data_d = read_data_q;
    prog_d      = prog_q;
    page_d      = page_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (res.valid) begin
      out_valid_d = 1'b1;
      read_data_d = res.read_data;
      prog_d      = res.programmed;
      page_d      = res.page;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    read_data_q <= read_data_d;
    prog_q      <= prog_d;
    page_q      <= page_d;
  end

  assign out_valid_o       = out_valid_q;
  assign read_data_o       = read_data_q;
  assign page_programmed_o = prog_q;
  assign programmed_page_o = page_q;

`ifndef NO_ASSERTIONS
  a_res_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> !out_valid_q)
    else $error("result produced while result register is full");

  a_accept_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !seq_busy && !out_valid_q)
    else $error("transaction accepted while busy");

  a_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !page_programmed_o |-> programmed_page_o == '0)
    else $error("programmed page nonzero without program");

  a_read_no_prog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && res.read_data != '0 |-> !res.programmed)
    else $error("read result reports a program");
`endif

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for flash_page_write_back_cache: a directed table, then random
// page traffic, with a word-level flash and page-cache predictor. Depends on fpwb_pkg
// and the RTL top level.
module tb_top import fpwb_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam bit EXP_TYPED = 1'b1;
  localparam bit EXP_MODEL = 1'b0;
  localparam int unsigned DIR_ROWS = 24;
  localparam int unsigned RAND_ITEMS = 1430;
  localparam int unsigned QUIET_TAIL = 150;
  localparam int unsigned HOLD_AT = 60;
  localparam int unsigned HOLD_CYCLES = 12 * PAGE_WORDS;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    logic [REQ_W-1:0]       req;
    logic [ADDR_W-1:0]      addr;
    logic [DATA_W-1:0]      data;
    bit                     kind;
    logic [DATA_W-1:0]      read_data;
    logic                   programmed;
    logic [PROG_PAGE_W-1:0] page;
  } access_t;

  typedef struct {
    logic [DATA_W-1:0]      read_data;
    logic                   programmed;
    logic [PROG_PAGE_W-1:0] page;
  } access_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [REQ_W-1:0]       req_type_i;
  logic [ADDR_W-1:0]      word_addr_i;
  logic [DATA_W-1:0]      write_data_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [DATA_W-1:0]      read_data_o;
  logic                   page_programmed_o;
  logic [PROG_PAGE_W-1:0] programmed_page_o;

  flash_page_write_back_cache dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .req_type_i        (req_type_i),
    .word_addr_i       (word_addr_i),
    .write_data_i      (write_data_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .read_data_o       (read_data_o),
    .page_programmed_o (page_programmed_o),
    .programmed_page_o (programmed_page_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // predictor state
  logic [DATA_W-1:0] flash_img [FLASH_WORDS];
  logic [DATA_W-1:0] page_img [PAGE_WORDS];
  int unsigned       img_page;
  bit                img_valid;

  access_t        dir_tbl [DIR_ROWS];
  access_t        access_q [$];
  access_result_t pending_results [$];

  int unsigned send_idx, send_gap;
  int unsigned n_accepted, n_results, n_fail;
  int unsigned stall_burst, hold_left;
  bit          hold_done;
  int unsigned n_reads, n_writes, n_flushes, n_unused, n_programs, n_clean_flushes;
  longint unsigned cycle_cnt, cycle_limit;

  function automatic logic write_back_page(output logic [PROG_PAGE_W-1:0] pg);
    logic        differs;
    int unsigned base;
    differs = 1'b0;
    pg = '0;
    if (img_valid && img_page < FLASH_PAGES) begin
      base = img_page * PAGE_WORDS;
      for (int i = 0; i < PAGE_WORDS; i++)
        if (flash_img[base + i] != page_img[i]) differs = 1'b1;
      if (differs) begin
        for (int i = 0; i < PAGE_WORDS; i++) flash_img[base + i] = page_img[i];
        pg = PROG_PAGE_W'(img_page);
        n_programs++;
      end else begin
        n_clean_flushes++;
      end
    end
    img_valid = 1'b0;
    return differs;
  endfunction

  function automatic access_result_t predict_flash_access(logic [REQ_W-1:0] req,
                                                          logic [ADDR_W-1:0] addr,
                                                          logic [DATA_W-1:0] data);
    access_result_t res;
    int unsigned    pg, off;
    res = '{read_data: '0, programmed: 1'b0, page: '0};
    pg = int'(addr) / PAGE_WORDS;
    off = int'(addr) % PAGE_WORDS;
    case (req)
      REQ_READ: begin
        n_reads++;
        if (pg < FLASH_PAGES) res.read_data = flash_img[pg * PAGE_WORDS + off];
      end
      REQ_WRITE: begin
        n_writes++;
        if (pg < FLASH_PAGES) begin
          if (!img_valid || img_page != pg) begin
            res.programmed = write_back_page(res.page);
            for (int i = 0; i < PAGE_WORDS; i++) page_img[i] = flash_img[pg * PAGE_WORDS + i];
            img_page = pg;
            img_valid = 1'b1;
          end
          page_img[off] = data;
        end
      end
      REQ_FLUSH: begin
        n_flushes++;
        res.programmed = write_back_page(res.page);
      end
      default: n_unused++;
    endcase
    return res;
  endfunction

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (got !== want) begin
      n_fail++;
      if (n_fail <= MAX_REPORTS)
        $display("mismatch in %s of result %0d: expected %h, got %h",
                 name, n_results, want, got);
    end
  endfunction

  // sender
  always @(posedge clk_i) begin
    access_result_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        want = predict_flash_access(req_type_i, word_addr_i, write_data_i);
        if (access_q[n_accepted].kind == EXP_TYPED)
          want = '{read_data: access_q[n_accepted].read_data,
                   programmed: access_q[n_accepted].programmed,
                   page: access_q[n_accepted].page};
        pending_results.push_back(want);
        n_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (send_idx >= access_q.size()) begin
          in_valid_i <= 1'b0;
        end else if (send_idx + QUIET_TAIL < access_q.size() && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 7);
          in_valid_i <= 1'b0;
        end else begin
          req_type_i   <= access_q[send_idx].req;
          word_addr_i  <= access_q[send_idx].addr;
          write_data_i <= access_q[send_idx].data;
          in_valid_i   <= 1'b1;
          send_idx++;
        end
      end
    end
  end

  // receiver
  always @(posedge clk_i) begin
    access_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $display("result %0d arrived with no transaction outstanding: %h %b %h",
                     n_results, read_data_o, page_programmed_o, programmed_page_o);
        end else begin
          want = pending_results.pop_front();
          check_field("read_data", want.read_data, read_data_o);
          check_field("page_programmed", DATA_W'(want.programmed), DATA_W'(page_programmed_o));
          check_field("programmed_page", DATA_W'(want.page), DATA_W'(programmed_page_o));
        end
        n_results++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!hold_done && n_accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else if (stall_burst > 0) begin
        stall_burst--;
        out_stall_i <= 1'b1;
      end else if (n_results + QUIET_TAIL < access_q.size() && $urandom_range(0, 7) == 0) begin
        stall_burst = $urandom_range(0, 7);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_limit != 0 && cycle_cnt > cycle_limit) begin
      $display("timeout after %0d cycles, %0d of %0d transactions accepted",
               cycle_cnt, n_accepted, access_q.size());
      $display("flash_page_write_back_cache regression: fail");
      $finish;
    end
  end

  initial begin
    access_t     item;
    int unsigned cur_pg, r;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    req_type_i   = '0;
    word_addr_i  = '0;
    write_data_i = '0;
    out_stall_i  = 1'b0;
    cycle_cnt    = 0;
    cycle_limit  = 0;
    img_page     = 0;
    img_valid    = 1'b0;
    foreach (flash_img[i]) flash_img[i] = ERASED_WORD;
    foreach (page_img[i]) page_img[i] = '0;

    dir_tbl = '{
      '{REQ_READ,   14'h0000, 32'h0,        EXP_TYPED, ERASED_WORD,  1'b0, 4'h0},
      '{REQ_READ,   14'h3fff, 32'h0,        EXP_TYPED, ERASED_WORD,  1'b0, 4'h0},
      '{REQ_UNUSED, 14'h3fff, 32'hffffffff, EXP_TYPED, 32'h0,        1'b0, 4'h0},
      '{REQ_FLUSH,  14'h0000, 32'h0,        EXP_TYPED, 32'h0,        1'b0, 4'h0},
      '{REQ_WRITE,  14'h0000, 32'h0,        EXP_TYPED, 32'h0,        1'b0, 4'h0},
      '{REQ_WRITE,  14'h03ff, 32'hffffffff, EXP_TYPED, 32'h0,        1'b0, 4'h0},
      '{REQ_READ,   14'h0000, 32'h0,        EXP_TYPED, ERASED_WORD,  1'b0, 4'h0},
      '{REQ_FLUSH,  14'h0000, 32'h0,        EXP_TYPED, 32'h0,        1'b1, 4'h0},
      '{REQ_READ,   14'h0000, 32'h0,        EXP_TYPED, 32'h0,        1'b0, 4'h0},
      '{REQ_WRITE,  14'h3fff, 32'ha5a5a5a5, EXP_TYPED, 32'h0,        1'b0, 4'h0},
      '{REQ_FLUSH,  14'h0000, 32'h0,        EXP_TYPED, 32'h0,        1'b1, 4'hf},
      '{REQ_WRITE,  14'h3fff, 32'ha5a5a5a5, EXP_TYPED, 32'h0,        1'b0, 4'h0},
      '{REQ_FLUSH,  14'h0000, 32'h0,        EXP_TYPED, 32'h0,        1'b0, 4'h0},
      '{REQ_WRITE,  14'h3fff, 32'h5a5a5a5a, EXP_TYPED, 32'h0,        1'b0, 4'h0},
      '{REQ_WRITE,  14'h0c05, 32'h12345678, EXP_TYPED, 32'h0,        1'b1, 4'hf},
      '{REQ_WRITE,  14'h0c00, 32'h0,        EXP_MODEL, 32'h0,        1'b0, 4'h0},
      '{REQ_READ,   14'h3fff, 32'h0,        EXP_TYPED, 32'h5a5a5a5a, 1'b0, 4'h0},
      '{REQ_READ,   14'h0c05, 32'h0,        EXP_TYPED, ERASED_WORD,  1'b0, 4'h0},
      '{REQ_FLUSH,  14'h0000, 32'h0,        EXP_TYPED, 32'h0,        1'b1, 4'h3},
      '{REQ_READ,   14'h0c05, 32'h0,        EXP_MODEL, 32'h0,        1'b0, 4'h0},
      '{REQ_WRITE,  14'h1e00, 32'h0,        EXP_MODEL, 32'h0,        1'b0, 4'h0},
      '{REQ_UNUSED, 14'h1e00, 32'hffffffff, EXP_TYPED, 32'h0,        1'b0, 4'h0},
      '{REQ_READ,   14'h1e00, 32'h0,        EXP_TYPED, ERASED_WORD,  1'b0, 4'h0},
      '{REQ_FLUSH,  14'h3fff, 32'hffffffff, EXP_TYPED, 32'h0,        1'b1, 4'h7}
    };
    foreach (dir_tbl[i]) access_q.push_back(dir_tbl[i]);

    // mostly traffic on one working page, with occasional page switches and flushes
    cur_pg = $urandom_range(0, FLASH_PAGES - 1);
    repeat (RAND_ITEMS) begin
      if ($urandom_range(0, 99) < 3) cur_pg = $urandom_range(0, FLASH_PAGES - 1);
      r = $urandom_range(0, 99);
      item = dir_tbl[0];
      item.kind = EXP_MODEL;
      item.addr = ADDR_W'(cur_pg * PAGE_WORDS + $urandom_range(0, PAGE_WORDS - 1));
      item.data = $urandom();
      if (r < 50) begin
        item.req = REQ_WRITE;
        if (r < 10) item.data = ERASED_WORD;
      end else if (r < 80) begin
        item.req = REQ_READ;
        if (r >= 70) item.addr = ADDR_W'($urandom());
      end else if (r < 83) begin
        item.req = REQ_FLUSH;
      end else if (r < 86) begin
        item.req = REQ_UNUSED;
        item.addr = ADDR_W'($urandom());
      end else if (r < 88) begin
        item.req = REQ_WRITE;
        item.addr = ADDR_W'($urandom());
      end else begin
        item.req = REQ_READ;
      end
      access_q.push_back(item);
    end
    cycle_limit = 4 * longint'(access_q.size()) * (3 * PAGE_WORDS + 40) + 4 * HOLD_CYCLES;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (n_accepted < access_q.size()) @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d transactions: %0d reads, %0d writes, %0d flushes, %0d unused codes",
             n_accepted, n_reads, n_writes, n_flushes, n_unused);
    $display("%0d page programs, %0d write-backs of unchanged pages, %0d failures",
             n_programs, n_clean_flushes, n_fail);
    if (n_fail == 0 && pending_results.size() == 0) begin
      $display("flash_page_write_back_cache regression: pass");
    end else begin
      $display("flash_page_write_back_cache regression: fail");
    end
    $finish;
  end

endmodule
